[hw/rtl/tlafk_pkg.sv]
package tlafk_pkg;

	// CORDIC iteration count, one pipeline stage per iteration
	localparam int CORDIC_STEPS = 16;

	// Field widths
	localparam int ANG_W = 18;
	localparam int LEN_W = 10;
	localparam int OUT_W = 20;

	// Reduced angle (counts of 1/256 degree), quadrant-folded angle, CORDIC z
	localparam int RED_W = ANG_W + 1;
	localparam int QUAD_W = 16;
	localparam int Z_FRAC_SHIFT = 12;
	localparam int Z_W = QUAD_W + Z_FRAC_SHIFT + 1;

	// CORDIC x and y: Q30 with headroom
	localparam int XY_W = 33;

	// Product and sum widths in the merge stage
	localparam int PROD_W = XY_W + LEN_W + 1;
	localparam int SUM_W = PROD_W + 1;
	localparam int ROUND_SHIFT = 22;

	// Angle constants in counts of 1/256 degree
	localparam int ANGLE_FULL = 92160;
	localparam int ANGLE_HALF = 46080;
	localparam int ANGLE_QUARTER = 23040;

	// Pre-scaled CORDIC gain in Q30
	localparam int CORDIC_GAIN_Q30 = 652032874;

	// Output saturation bounds
	localparam int OUT_MAX = 524287;
	localparam int OUT_MIN = -524288;

	// Link length after reset
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(100);

	// Lanes before the merge plus merge stages
	localparam int PIPE_DEPTH = CORDIC_STEPS + 5;

	// Configuration register indexes
	localparam logic REG_FIRST_LEN = 1'b0;
	localparam logic REG_SECOND_LEN = 1'b1;

	// atan(2^-i) in degrees with 20 fraction bits
	localparam logic signed [Z_W-1:0] ATAN_DEG_Q20 [24] = '{
		Z_W'(47185920), Z_W'(27855475), Z_W'(14718068), Z_W'(7471121),
		Z_W'(3750058), Z_W'(1876857), Z_W'(938658), Z_W'(469357),
		Z_W'(234682), Z_W'(117342), Z_W'(58671), Z_W'(29335),
		Z_W'(14668), Z_W'(7334), Z_W'(3667), Z_W'(1833),
		Z_W'(917), Z_W'(458), Z_W'(229), Z_W'(115),
		Z_W'(57), Z_W'(29), Z_W'(14), Z_W'(7)
	};

	// Cosine and sine from one lane, before the half-turn correction
	typedef struct packed {
		logic flip;
		logic signed [XY_W-1:0] cos_v;
		logic signed [XY_W-1:0] sin_v;
	} cs_t;

endpackage

[hw/rtl/tlafk_cordic_lane.sv]
module tlafk_cordic_lane (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [tlafk_pkg::ANG_W-1:0]    angle,
	output tlafk_pkg::cs_t                        res
);

	localparam int RW = tlafk_pkg::RED_W;
	localparam int ZW = tlafk_pkg::Z_W;
	localparam int XW = tlafk_pkg::XY_W;
	localparam int QW = tlafk_pkg::QUAD_W;
	localparam int STEPS = tlafk_pkg::CORDIC_STEPS;

	localparam logic signed [RW-1:0] FULL = RW'(tlafk_pkg::ANGLE_FULL);
	localparam logic signed [RW-1:0] HALF = RW'(tlafk_pkg::ANGLE_HALF);
	localparam logic signed [RW-1:0] QUARTER = RW'(tlafk_pkg::ANGLE_QUARTER);
	localparam logic signed [XW-1:0] GAIN = XW'(tlafk_pkg::CORDIC_GAIN_Q30);

	logic signed [RW-1:0] ang_ext;
	logic signed [RW-1:0] red_c;
	logic signed [RW-1:0] red_s1;
	logic signed [RW-1:0] quad_c;
	logic                 flip_c;
	logic signed [ZW-1:0] z_s2;
	logic                 flip_s2;

	logic signed [XW-1:0] x_s [STEPS];
	logic signed [XW-1:0] y_s [STEPS];
	logic signed [ZW-1:0] z_s [STEPS];
	logic                 flip_s [STEPS];

	// Reduce into (-180, 180] degrees; one full turn always suffices
	assign ang_ext = {angle[tlafk_pkg::ANG_W-1], angle};

	always_comb begin
		if (ang_ext > HALF) begin
			red_c = ang_ext - FULL;
		end else if (ang_ext <= -HALF) begin
			red_c = ang_ext + FULL;
		end else begin
			red_c = ang_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1 <= red_c;
		end
	end

	// Fold into [-90, 90] degrees, remember the half-turn
	always_comb begin
		if (red_s1 > QUARTER) begin
			quad_c = red_s1 - HALF;
			flip_c = 1'b1;
		end else if (red_s1 < -QUARTER) begin
			quad_c = red_s1 + HALF;
			flip_c = 1'b1;
		end else begin
			quad_c = red_s1;
			flip_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2 <= {{(ZW-QW-tlafk_pkg::Z_FRAC_SHIFT){quad_c[QW-1]}}, quad_c[QW-1:0],
				{tlafk_pkg::Z_FRAC_SHIFT{1'b0}}};
			flip_s2 <= flip_c;
		end
	end

	// One rotation per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [XW-1:0] xi;
		logic signed [XW-1:0] yi;
		logic signed [ZW-1:0] zi;
		logic                 fi;

		if (i == 0) begin : g_first
			assign xi = GAIN;
			assign yi = '0;
			assign zi = z_s2;
			assign fi = flip_s2;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign fi = flip_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!zi[ZW-1]) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - tlafk_pkg::ATAN_DEG_Q20[i];
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + tlafk_pkg::ATAN_DEG_Q20[i];
				end
				flip_s[i] <= fi;
			end
		end
	end

	assign res.flip = flip_s[STEPS-1];
	assign res.cos_v = x_s[STEPS-1];
	assign res.sin_v = y_s[STEPS-1];

endmodule

[hw/rtl/tlafk_merge.sv]
module tlafk_merge (
	input  logic                                  clk,
	input  logic                                  en,
	input  tlafk_pkg::cs_t                        lane_a,
	input  tlafk_pkg::cs_t                        lane_b,
	input  logic [tlafk_pkg::LEN_W-1:0]           len_a,
	input  logic [tlafk_pkg::LEN_W-1:0]           len_b,
	output logic signed [tlafk_pkg::OUT_W-1:0]    end_x,
	output logic signed [tlafk_pkg::OUT_W-1:0]    end_y
);

	localparam int XW = tlafk_pkg::XY_W;
	localparam int PW = tlafk_pkg::PROD_W;
	localparam int SW = tlafk_pkg::SUM_W;
	localparam int OW = tlafk_pkg::OUT_W;

	localparam logic signed [SW-1:0] ROUND = SW'(1) <<< (tlafk_pkg::ROUND_SHIFT - 1);
	localparam logic signed [SW-1:0] SAT_HI = SW'(tlafk_pkg::OUT_MAX);
	localparam logic signed [SW-1:0] SAT_LO = SW'(tlafk_pkg::OUT_MIN);

	logic signed [XW-1:0] ca_m1, sa_m1, cb_m1, sb_m1;
	logic signed [tlafk_pkg::LEN_W:0] la_m1, lb_m1;
	logic signed [PW-1:0] pxa_m2, pya_m2, pxb_m2, pyb_m2;
	logic signed [SW-1:0] sx_m3, sy_m3;
	logic signed [SW-1:0] shx, shy;

	// Apply the half-turn correction, sample link lengths
	always_ff @(posedge clk) begin
		if (en) begin
			ca_m1 <= lane_a.flip ? -lane_a.cos_v : lane_a.cos_v;
			sa_m1 <= lane_a.flip ? -lane_a.sin_v : lane_a.sin_v;
			cb_m1 <= lane_b.flip ? -lane_b.cos_v : lane_b.cos_v;
			sb_m1 <= lane_b.flip ? -lane_b.sin_v : lane_b.sin_v;
			la_m1 <= {1'b0, len_a};
			lb_m1 <= {1'b0, len_b};
		end
	end

	// Scale by link lengths, exact products at full product width
	always_ff @(posedge clk) begin
		if (en) begin
			pxa_m2 <= PW'(la_m1) * PW'(ca_m1);
			pya_m2 <= PW'(la_m1) * PW'(sa_m1);
			pxb_m2 <= PW'(lb_m1) * PW'(cb_m1);
			pyb_m2 <= PW'(lb_m1) * PW'(sb_m1);
		end
	end

	// Sum both links and add the rounding offset
	always_ff @(posedge clk) begin
		if (en) begin
			sx_m3 <= SW'(pxa_m2) + SW'(pxb_m2) + ROUND;
			sy_m3 <= SW'(pya_m2) + SW'(pyb_m2) + ROUND;
		end
	end

	// Drop to 8 fraction bits and clamp to the output range
	assign shx = sx_m3 >>> tlafk_pkg::ROUND_SHIFT;
	assign shy = sy_m3 >>> tlafk_pkg::ROUND_SHIFT;

	always_comb begin
		if (shx > SAT_HI) begin
			end_x = SAT_HI[OW-1:0];
		end else if (shx < SAT_LO) begin
			end_x = SAT_LO[OW-1:0];
		end else begin
			end_x = shx[OW-1:0];
		end

		if (shy > SAT_HI) begin
			end_y = SAT_HI[OW-1:0];
		end else if (shy < SAT_LO) begin
			end_y = SAT_LO[OW-1:0];
		end else begin
			end_y = shy[OW-1:0];
		end
	end

endmodule

[hw/rtl/two_link_arm_forward_kinematics.sv]
// From input transfer to m_axis_tvalid, data pass two reduction stages, one stage per CORDIC
// rotation, three merge stages and the output register.
// Throughput: one item per cycle while the skid register is empty; the two angle lanes and
// the merge are fully pipelined, and the skid register lets one more item enter while a
// result waits at the output. Reset clears the pipeline valid flags and the output side and
// sets both link lengths to 100; no other state is kept.
module two_link_arm_forward_kinematics (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [9:0]  cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [17:0] first_angle_deg, [35:18] second_angle_deg
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // [19:0] end_x, [39:20] end_y
);

	localparam int DEPTH = tlafk_pkg::PIPE_DEPTH;
	localparam int AW = tlafk_pkg::ANG_W;
	localparam int OW = tlafk_pkg::OUT_W;

	logic [tlafk_pkg::LEN_W-1:0] first_len_q, second_len_q;
	logic                        en;
	logic [DEPTH-1:0]            vld_q;
	logic                        pipe_vld;
	logic                        take;
	logic signed [AW-1:0]        first_angle_deg, second_angle_deg;
	tlafk_pkg::cs_t              lane_a, lane_b;
	logic signed [OW-1:0]        end_x, end_y;
	logic                        out_vld_q, skid_vld_q;
	logic [2*OW-1:0]             out_q, skid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q <= tlafk_pkg::LEN_RESET;
			second_len_q <= tlafk_pkg::LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tlafk_pkg::REG_FIRST_LEN:  first_len_q <= cfg_data;
				tlafk_pkg::REG_SECOND_LEN: second_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline advances unless the skid register holds a result
	assign en = !skid_vld_q;
	assign s_axis_tready = en;

	assign first_angle_deg = s_axis_tdata[AW-1:0];
	assign second_angle_deg = s_axis_tdata[2*AW-1:AW];

	// Valid flags travel alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
		end
	end

	assign pipe_vld = vld_q[DEPTH-1];

	// One lane per joint angle
	tlafk_cordic_lane u_lane_a (
		.clk   (clk),
		.en    (en),
		.angle (first_angle_deg),
		.res   (lane_a)
	);

	tlafk_cordic_lane u_lane_b (
		.clk   (clk),
		.en    (en),
		.angle (second_angle_deg),
		.res   (lane_b)
	);

	// Combine lanes into the end point
	tlafk_merge u_merge (
		.clk    (clk),
		.en     (en),
		.lane_a (lane_a),
		.lane_b (lane_b),
		.len_a  (first_len_q),
		.len_b  (second_len_q),
		.end_x  (end_x),
		.end_y  (end_y)
	);

	// Output register with skid stage
	assign take = out_vld_q & m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (pipe_vld) begin
			if (out_vld_q && !take) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (pipe_vld) begin
			if (out_vld_q && !take) begin
				skid_q <= {end_y, end_x};
			end else begin
				out_q <= {end_y, end_x};
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_q;

endmodule
